// File: hw/rtl/b64d_pkg.sv
// Shared types, constants and the character map of the Base64 stream decoder.
package b64d_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SLASH   = 8'h2f;

   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;
   localparam logic [6:0] INDEX_PLUS  = 7'd62;
   localparam logic [6:0] INDEX_SLASH = 7'd63;
   localparam logic [6:0] BAD_INDEX   = 7'd64;

   localparam logic [1:0] POS_FOURTH = 2'd3;

   typedef struct packed {
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [1:0] count;
      logic       error;
      logic       last;
   } group_rec_type;

   typedef struct packed {
      logic          valid;
      group_rec_type rec;
   } group_push_type;

   function automatic logic [6:0] char_to_index(input logic [7:0] ch);
      logic [7:0] t;
      logic [6:0] r;
      t = 8'd0;
      r = BAD_INDEX;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         t = ch - CHAR_UPPER_A;
         r = {1'b0, t[5:0]};
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         t = ch - CHAR_LOWER_A + LOWER_BASE;
         r = {1'b0, t[5:0]};
      end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
         t = ch - CHAR_DIGIT_0 + DIGIT_BASE;
         r = {1'b0, t[5:0]};
      end else if (ch == CHAR_PLUS) begin
         r = INDEX_PLUS;
      end else if (ch == CHAR_SLASH) begin
         r = INDEX_SLASH;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/b64d_front.sv
// Front end: maps characters, collects groups of four and builds byte-group records.
module b64d_front
   import b64d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_char_in,
   input  logic           req_is_last,
   input  logic           queue_ready,
   output group_push_type push
);

   logic [6:0] idx_ff [3];
   logic [1:0] pos_ff, pos_in;
   logic       sticky_ff, sticky_in;
   logic [6:0] idx_now;
   logic       take;
   logic       err_now;
   logic [5:0] a, b, c, d;

   assign req_ready = queue_ready;
   assign take      = req_valid && queue_ready;
   assign idx_now   = char_to_index(req_char_in);
   assign a = idx_ff[0][5:0];
   assign b = idx_ff[1][5:0];
   assign c = idx_ff[2][5:0];
   assign d = idx_now[5:0];
   assign err_now = sticky_ff || idx_ff[0][6] || idx_ff[1][6];

   always_comb begin
      pos_in          = pos_ff;
      sticky_in       = sticky_ff;
      push.valid      = 1'b0;
      push.rec.data0  = {a, b[5:4]};
      push.rec.data1  = {b[3:0], c[5:2]};
      push.rec.data2  = {c[1:0], d};
      push.rec.count  = idx_ff[2][6] ? 2'd1 : (idx_now[6] ? 2'd2 : 2'd3);
      push.rec.error  = 1'b0;
      push.rec.last   = req_is_last;
      if (take) begin
         if (pos_ff != POS_FOURTH) begin
            pos_in = pos_ff + 2'd1;
            if (req_is_last) begin
               pos_in         = 2'd0;
               sticky_in      = 1'b0;
               push.valid     = 1'b1;
               push.rec.data0 = 8'd0;
               push.rec.count = 2'd1;
               push.rec.error = 1'b1;
            end
         end else begin
            pos_in = 2'd0;
            if (req_is_last) begin
               sticky_in  = 1'b0;
               push.valid = 1'b1;
               if (err_now) begin
                  push.rec.data0 = 8'd0;
                  push.rec.count = 2'd1;
                  push.rec.error = 1'b1;
               end
            end else begin
               sticky_in  = err_now;
               push.valid = !err_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 2'd0;
         sticky_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         sticky_ff <= sticky_in;
      end
      if (take && pos_ff != POS_FOURTH) begin
         idx_ff[pos_ff] <= idx_now;
      end
   end

endmodule

// File: hw/rtl/b64d_queue.sv
// Short queue of byte-group records between the front and back ends.
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  group_push_type push,
   output logic           queue_ready,
   output logic           head_valid,
   output group_rec_type  head_rec,
   input  logic           pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   group_rec_type       entries_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign queue_ready = (count_ff != FullCnt);
   assign head_valid  = (count_ff != '0);
   assign head_rec    = entries_ff[rd_ptr_ff];
   assign do_push     = push.valid && queue_ready;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.rec;
      end
   end

endmodule

// File: hw/rtl/b64d_back.sv
// Back end: unpacks byte-group records into one result transfer per cycle while rsp_ready is high.
module b64d_back
   import b64d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  group_rec_type head_rec,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_data_byte,
   output logic          rsp_error,
   output logic          rsp_last_out
);

   logic [1:0] sel_ff, sel_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       error_ff, error_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_byte;

   assign load       = head_valid && (!valid_ff || rsp_ready);
   assign final_byte = (sel_ff == head_rec.count - 2'd1);
   assign pop        = load && final_byte;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      error_in = error_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         error_in = head_rec.error;
         last_in  = head_rec.last && final_byte;
         sel_in   = final_byte ? 2'd0 : sel_ff + 2'd1;
         case (sel_ff)
            2'd0:    data_in = head_rec.data0;
            2'd1:    data_in = head_rec.data1;
            default: data_in = head_rec.data2;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
      data_ff  <= data_in;
      error_ff <= error_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_error     = error_ff;
   assign rsp_last_out  = last_ff;

endmodule

// File: hw/rtl/base64_stream_decoder_top.sv
// Top level of the Base64 stream decoder.
// Throughput: one character accepted per cycle while the queue is not full;
// results leave one per cycle while rsp_ready is high. A group's bytes pass
// through a queue record and then the output register to rsp_data_byte.
// A queue of QUEUE_DEPTH group records decouples character intake from output.
// Reset clears the group position, the sticky error, the queue and the output.
module base64_stream_decoder_top
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_error,
   output logic       rsp_last_out
);

   group_push_type push;
   group_rec_type  head_rec;
   logic           queue_ready;
   logic           head_valid;
   logic           pop;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .req_is_last (req_is_last),
      .queue_ready (queue_ready),
      .push        (push)
   );

   b64d_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_ready (queue_ready),
      .head_valid  (head_valid),
      .head_rec    (head_rec),
      .pop         (pop)
   );

   b64d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_rec      (head_rec),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_error     (rsp_error),
      .rsp_last_out  (rsp_last_out)
   );

endmodule
